[rtl/core/assert_macros.svh]
// assertion macros for the rtl, included by ip_transport_classifier_unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_CLK_ALWAYS(label, prop, msg)
`endif
`endif

[rtl/core/itc_pkg.sv]
// types, codes and helpers for the ip transport classifier
`timescale 1ns / 1ps
package itc_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } pkt_t;

  typedef struct packed {
    logic       is_match;
    logic [2:0] status;
    logic [7:0] protocol;
  } verdict_t;

  typedef enum logic [2:0] {
    PH_VERSION = 3'd0,
    PH_IPV4    = 3'd1,
    PH_IPV6    = 3'd2,
    PH_EXT     = 3'd3,
    PH_SKIP    = 3'd4,
    PH_DONE    = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    ST_MATCH     = 3'd0,
    ST_OTHER     = 3'd1,
    ST_TRUNC     = 3'd2,
    ST_NOTIP     = 3'd3,
    ST_LATERFRAG = 3'd4
  } status_t;

  localparam logic [3:0] VER_IPV4 = 4'd4;
  localparam logic [3:0] VER_IPV6 = 4'd6;

  localparam logic [7:0] PROTO_HOPOPT = 8'd0;
  localparam logic [7:0] PROTO_TCP    = 8'd6;
  localparam logic [7:0] PROTO_UDP    = 8'd17;
  localparam logic [7:0] PROTO_ROUTE  = 8'd43;
  localparam logic [7:0] PROTO_FRAG   = 8'd44;
  localparam logic [7:0] PROTO_AH     = 8'd51;
  localparam logic [7:0] PROTO_DSTOPT = 8'd60;

  localparam int OFS_W = 17;

  localparam logic [OFS_W-1:0] IPV4_PROTO_IDX = 17'd9;
  localparam logic [OFS_W-1:0] IPV4_LAST_IDX  = 17'd19;
  localparam logic [OFS_W-1:0] IPV6_NH_IDX    = 17'd6;
  localparam logic [OFS_W-1:0] IPV6_LAST_IDX  = 17'd39;
  localparam logic [OFS_W-1:0] IPV6_EXT_START = 17'd40;
  localparam logic [OFS_W-1:0] FRAG_HDR_BYTES = 17'd8;

  localparam logic [OFS_W-1:0] REL_LEN      = 17'd1;
  localparam logic [OFS_W-1:0] REL_FRAG_HI  = 17'd2;
  localparam logic [OFS_W-1:0] REL_FRAG_LO  = 17'd3;
  localparam logic [OFS_W-1:0] REL_FRAG_END = 17'd7;

  function automatic logic is_transport(input logic [7:0] t);
    return (t == PROTO_TCP) || (t == PROTO_UDP);
  endfunction

  function automatic logic is_ext(input logic [7:0] t);
    return (t == PROTO_HOPOPT) || (t == PROTO_ROUTE) || (t == PROTO_DSTOPT) ||
           (t == PROTO_AH) || (t == PROTO_FRAG);
  endfunction

endpackage

[rtl/core/ip_transport_classifier_unit.sv]
// Takes an IP packet one byte per request and reports whether it carries TCP or UDP, walking
// the IPv6 extension header chain (hop-by-hop, routing, destination options, AH, fragment).
// One byte is accepted per unstalled cycle: each byte goes through a single pass of compare and
// offset-add logic against the parser state. The verdict for a packet is registered and shows
// on the verdict channel the cycle after the byte with last_byte set; the next packet's first
// byte may be accepted in that same cycle. The pkt channel stalls only while a verdict is held
// by a stalled downstream. Bytes at index MAX_PACKET_BYTES and beyond are passed over unparsed.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ip_transport_classifier_unit #(
  parameter int MAX_PACKET_BYTES = 65535
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             pkt_valid,
  output logic             pkt_stall,
  input  itc_pkg::pkt_t    pkt,
  output logic             verdict_valid,
  input  logic             verdict_stall,
  output itc_pkg::verdict_t verdict
);

  localparam int IDX_W = $clog2(MAX_PACKET_BYTES + 1);
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_PACKET_BYTES);

  logic [IDX_W-1:0]           byte_index, byte_index_next;
  itc_pkg::phase_t            phase, phase_next;
  logic [itc_pkg::OFS_W-1:0]  hdr_ofs, hdr_ofs_next;
  logic [7:0]                 cur_type, cur_type_next;
  logic [7:0]                 pend_type, pend_type_next;
  logic                       frag_flag, frag_flag_next;
  itc_pkg::status_t           vstatus, vstatus_next;
  logic                       verdict_valid_next;
  itc_pkg::verdict_t          verdict_next;

  logic                       accept;
  logic                       last_accept;
  logic [7:0]                 b;
  logic [itc_pkg::OFS_W-1:0]  idx17;
  logic [itc_pkg::OFS_W-1:0]  rel;
  logic [11:0]                ext_len;
  logic [8:0]                 b_plus1, b_plus2;

  // parsed values for the current byte, before the end-of-packet reset
  itc_pkg::phase_t            p_phase;
  logic [itc_pkg::OFS_W-1:0]  p_ofs;
  logic [7:0]                 p_cur, p_pend;
  logic                       p_flag;
  itc_pkg::status_t           p_status;
  itc_pkg::status_t           final_st;

  assign pkt_stall   = verdict_valid && verdict_stall;
  assign accept      = pkt_valid && !pkt_stall;
  assign last_accept = accept && pkt.last_byte;
  assign b           = pkt.data_byte;
  assign idx17       = itc_pkg::OFS_W'(byte_index);
  assign rel         = idx17 - hdr_ofs;
  assign b_plus1     = {1'b0, b} + 9'd1;
  assign b_plus2     = {1'b0, b} + 9'd2;
  // AH counts 4-byte units plus two, the others 8-byte units plus one
  assign ext_len     = (cur_type == itc_pkg::PROTO_AH) ? {1'b0, b_plus2, 2'b00}
                                                        : {b_plus1, 3'b000};

  always_comb begin
    p_phase  = phase;
    p_ofs    = hdr_ofs;
    p_cur    = cur_type;
    p_pend   = pend_type;
    p_flag   = frag_flag;
    p_status = vstatus;

    if (byte_index < IDX_MAX) begin
      case (phase)
        itc_pkg::PH_VERSION: begin
          if (b[7:4] == itc_pkg::VER_IPV4) begin
            p_phase = itc_pkg::PH_IPV4;
          end else if (b[7:4] == itc_pkg::VER_IPV6) begin
            p_phase = itc_pkg::PH_IPV6;
          end else begin
            p_phase  = itc_pkg::PH_DONE;
            p_status = itc_pkg::ST_NOTIP;
          end
        end
        itc_pkg::PH_IPV4: begin
          if (idx17 == itc_pkg::IPV4_PROTO_IDX) begin
            p_cur = b;
          end
          if (idx17 == itc_pkg::IPV4_LAST_IDX) begin
            p_phase  = itc_pkg::PH_DONE;
            p_status = itc_pkg::is_transport(cur_type) ? itc_pkg::ST_MATCH : itc_pkg::ST_OTHER;
          end
        end
        itc_pkg::PH_IPV6: begin
          if (idx17 == itc_pkg::IPV6_NH_IDX) begin
            p_cur = b;
          end
          if (idx17 == itc_pkg::IPV6_LAST_IDX) begin
            if (itc_pkg::is_transport(cur_type)) begin
              p_phase  = itc_pkg::PH_DONE;
              p_status = itc_pkg::ST_MATCH;
            end else if (itc_pkg::is_ext(cur_type)) begin
              p_phase = itc_pkg::PH_SKIP;
              p_ofs   = itc_pkg::IPV6_EXT_START;
              p_pend  = cur_type;
            end else begin
              p_phase  = itc_pkg::PH_DONE;
              p_status = itc_pkg::ST_OTHER;
            end
          end
        end
        itc_pkg::PH_EXT: begin
          if (rel == itc_pkg::REL_LEN) begin
            if (cur_type == itc_pkg::PROTO_FRAG) begin
              p_flag = 1'b0;
            end else begin
              p_ofs   = hdr_ofs + itc_pkg::OFS_W'(ext_len);
              p_phase = itc_pkg::PH_SKIP;
            end
          end else if (cur_type == itc_pkg::PROTO_FRAG) begin
            // any nonzero fragment offset bit marks a later fragment
            if (rel == itc_pkg::REL_FRAG_HI && b != 8'd0) begin
              p_flag = 1'b1;
            end
            if (rel == itc_pkg::REL_FRAG_LO && b[7:3] != 5'd0) begin
              p_flag = 1'b1;
            end
            if (rel == itc_pkg::REL_FRAG_END) begin
              if (frag_flag) begin
                p_phase  = itc_pkg::PH_DONE;
                p_status = itc_pkg::ST_LATERFRAG;
              end else begin
                p_ofs   = hdr_ofs + itc_pkg::FRAG_HDR_BYTES;
                p_phase = itc_pkg::PH_SKIP;
              end
            end
          end
        end
        itc_pkg::PH_SKIP: begin
          if (idx17 == hdr_ofs) begin
            p_cur = pend_type;
            if (itc_pkg::is_transport(pend_type)) begin
              p_phase  = itc_pkg::PH_DONE;
              p_status = itc_pkg::ST_MATCH;
            end else if (itc_pkg::is_ext(pend_type)) begin
              p_phase = itc_pkg::PH_EXT;
              p_ofs   = idx17;
              p_pend  = b;
            end else begin
              p_phase  = itc_pkg::PH_DONE;
              p_status = itc_pkg::ST_OTHER;
            end
          end
        end
        default: begin
        end
      endcase
    end

    final_st = (p_phase == itc_pkg::PH_DONE) ? p_status : itc_pkg::ST_TRUNC;

    byte_index_next    = byte_index;
    phase_next         = phase;
    hdr_ofs_next       = hdr_ofs;
    cur_type_next      = cur_type;
    pend_type_next     = pend_type;
    frag_flag_next     = frag_flag;
    vstatus_next       = vstatus;
    verdict_valid_next = verdict_valid && verdict_stall;
    verdict_next       = verdict;

    if (accept) begin
      if (pkt.last_byte) begin
        byte_index_next       = '0;
        phase_next            = itc_pkg::PH_VERSION;
        hdr_ofs_next          = '0;
        cur_type_next         = 8'd0;
        pend_type_next        = 8'd0;
        frag_flag_next        = 1'b0;
        vstatus_next          = itc_pkg::ST_TRUNC;
        verdict_valid_next    = 1'b1;
        verdict_next.is_match = (final_st == itc_pkg::ST_MATCH);
        verdict_next.status   = final_st;
        verdict_next.protocol = p_cur;
      end else begin
        byte_index_next = (byte_index < IDX_MAX) ? byte_index + IDX_W'(1) : byte_index;
        phase_next      = p_phase;
        hdr_ofs_next    = p_ofs;
        cur_type_next   = p_cur;
        pend_type_next  = p_pend;
        frag_flag_next  = p_flag;
        vstatus_next    = p_status;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index    <= '0;
      phase         <= itc_pkg::PH_VERSION;
      hdr_ofs       <= '0;
      cur_type      <= 8'd0;
      pend_type     <= 8'd0;
      frag_flag     <= 1'b0;
      vstatus       <= itc_pkg::ST_TRUNC;
      verdict_valid <= 1'b0;
    end else begin
      byte_index    <= byte_index_next;
      phase         <= phase_next;
      hdr_ofs       <= hdr_ofs_next;
      cur_type      <= cur_type_next;
      pend_type     <= pend_type_next;
      frag_flag     <= frag_flag_next;
      vstatus       <= vstatus_next;
      verdict_valid <= verdict_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    verdict <= verdict_next;
  end

  `ASSERT_CLK(a_stall_only_when_held, pkt_stall |-> verdict_valid, "stall without verdict")
  `ASSERT_CLK(a_last_gives_verdict, last_accept |=> verdict_valid, "last byte gave no verdict")
  `ASSERT_CLK(a_last_restarts, last_accept |=> (phase == itc_pkg::PH_VERSION), "no restart")
  `ASSERT_CLK(a_ext_after_start, phase == itc_pkg::PH_EXT |-> idx17 > hdr_ofs, "bad ext start")

endmodule

[tb/tb.sv]
// testbench for the ip transport classifier: byte stream in, one verdict out per packet
`timescale 1ns / 1ps
module tb;

  localparam int PKT_LIMIT      = 65535;  // bytes at this index and beyond are not parsed
  localparam int ITEM_TARGET    = 500;    // minimum bytes sent over the whole run
  localparam int PACKET_TARGET  = 30;
  localparam int HOLD_AT        = 20;     // verdict count at which the long back-pressure starts
  localparam int HOLD_CYCLES    = 400;
  localparam int QUIET_LIMIT    = 3000;
  localparam int DRAIN_CYCLES   = 20;

  class verdict_scoreboard;
    int                        byte_idx;
    itc_pkg::phase_t           phase;
    logic [itc_pkg::OFS_W-1:0] hdr_start;
    logic [7:0]                cur_type;
    logic [7:0]                next_type;
    bit                        frag_later;
    itc_pkg::status_t          outcome;
    bit                        decided;
    itc_pkg::verdict_t         expected_verdicts[$];
    int                        errors = 0;
    int                        verdicts_seen = 0;
    int                        status_hist[5];

    function new();
      foreach (status_hist[k]) status_hist[k] = 0;
      restart();
    endfunction

    function void restart();
      byte_idx   = 0;
      phase      = itc_pkg::PH_VERSION;
      hdr_start  = '0;
      cur_type   = 8'h00;
      next_type  = 8'h00;
      frag_later = 1'b0;
      outcome    = itc_pkg::ST_TRUNC;
      decided    = 1'b0;
    endfunction

    function void settle(itc_pkg::status_t s);
      outcome = s;
      decided = 1'b1;
      phase   = itc_pkg::PH_DONE;
    endfunction

    function bit is_l4(logic [7:0] t);
      return (t == itc_pkg::PROTO_TCP) || (t == itc_pkg::PROTO_UDP);
    endfunction

    function bit is_chain(logic [7:0] t);
      return (t == itc_pkg::PROTO_HOPOPT) || (t == itc_pkg::PROTO_ROUTE) ||
             (t == itc_pkg::PROTO_DSTOPT) || (t == itc_pkg::PROTO_AH) ||
             (t == itc_pkg::PROTO_FRAG);
    endfunction

    // one step of the header walk for byte b at index i
    function void walk_byte(int i, logic [7:0] b);
      int rel;
      int span;
      rel = i - int'(hdr_start);
      case (phase)
        itc_pkg::PH_VERSION: begin
          if (b[7:4] == itc_pkg::VER_IPV4) phase = itc_pkg::PH_IPV4;
          else if (b[7:4] == itc_pkg::VER_IPV6) phase = itc_pkg::PH_IPV6;
          else settle(itc_pkg::ST_NOTIP);
        end
        itc_pkg::PH_IPV4: begin
          if (i == itc_pkg::IPV4_PROTO_IDX) cur_type = b;
          if (i == itc_pkg::IPV4_LAST_IDX) begin
            if (is_l4(cur_type)) settle(itc_pkg::ST_MATCH);
            else settle(itc_pkg::ST_OTHER);
          end
        end
        itc_pkg::PH_IPV6: begin
          if (i == itc_pkg::IPV6_NH_IDX) cur_type = b;
          if (i == itc_pkg::IPV6_LAST_IDX) begin
            if (is_l4(cur_type)) begin
              settle(itc_pkg::ST_MATCH);
            end else if (is_chain(cur_type)) begin
              phase     = itc_pkg::PH_SKIP;
              hdr_start = itc_pkg::IPV6_EXT_START;
              next_type = cur_type;
            end else begin
              settle(itc_pkg::ST_OTHER);
            end
          end
        end
        itc_pkg::PH_EXT: begin
          if (rel == 1) begin
            if (cur_type == itc_pkg::PROTO_FRAG) begin
              frag_later = 1'b0;
            end else begin
              if (cur_type == itc_pkg::PROTO_AH) span = (int'(b) + 2) * 4;
              else span = (int'(b) + 1) * 8;
              hdr_start = hdr_start + itc_pkg::OFS_W'(span);
              phase     = itc_pkg::PH_SKIP;
            end
          end else if (cur_type == itc_pkg::PROTO_FRAG) begin
            if (rel == 2 && b != 8'h00) frag_later = 1'b1;
            if (rel == 3 && b[7:3] != 5'd0) frag_later = 1'b1;
            if (rel == 7) begin
              if (frag_later) begin
                settle(itc_pkg::ST_LATERFRAG);
              end else begin
                hdr_start = hdr_start + itc_pkg::FRAG_HDR_BYTES;
                phase     = itc_pkg::PH_SKIP;
              end
            end
          end
        end
        itc_pkg::PH_SKIP: begin
          if (i == int'(hdr_start)) begin
            cur_type = next_type;
            if (is_l4(cur_type)) begin
              settle(itc_pkg::ST_MATCH);
            end else if (is_chain(cur_type)) begin
              phase     = itc_pkg::PH_EXT;
              hdr_start = itc_pkg::OFS_W'(i);
              next_type = b;
            end else begin
              settle(itc_pkg::ST_OTHER);
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void note_request(itc_pkg::pkt_t p);
      itc_pkg::verdict_t v;
      if (byte_idx < PKT_LIMIT) begin
        walk_byte(byte_idx, p.data_byte);
        byte_idx++;
      end
      if (p.last_byte) begin
        v.status   = decided ? outcome : itc_pkg::ST_TRUNC;
        v.is_match = (v.status == itc_pkg::ST_MATCH);
        v.protocol = cur_type;
        expected_verdicts.push_back(v);
        restart();
      end
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_verdict(itc_pkg::verdict_t got);
      itc_pkg::verdict_t want;
      verdicts_seen++;
      if (expected_verdicts.size() == 0) begin
        $error("verdict with no packet outstanding: status %0d protocol %0d",
               got.status, got.protocol);
        errors++;
        return;
      end
      want = expected_verdicts.pop_front();
      status_hist[want.status]++;
      compare_field("is_match", 8'(want.is_match), 8'(got.is_match));
      compare_field("status", 8'(want.status), 8'(got.status));
      compare_field("protocol", want.protocol, got.protocol);
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              pkt_valid = 1'b0;
  logic              pkt_stall;
  itc_pkg::pkt_t     pkt = '0;
  logic              verdict_valid;
  logic              verdict_stall = 1'b0;
  itc_pkg::verdict_t verdict;

  verdict_scoreboard sb;
  logic [7:0] pkt_bytes[$];
  logic [7:0] chain[$];       // header types: chain[0] is the base next-header
  logic [7:0] ext_kinds[5] = '{itc_pkg::PROTO_HOPOPT, itc_pkg::PROTO_ROUTE,
                               itc_pkg::PROTO_DSTOPT, itc_pkg::PROTO_AH,
                               itc_pkg::PROTO_FRAG};
  int         bytes_sent = 0;
  int         packets_sent = 0;
  int         recv_gap_max = 0;

  ip_transport_classifier_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .pkt_valid     (pkt_valid),
    .pkt_stall     (pkt_stall),
    .pkt           (pkt),
    .verdict_valid (verdict_valid),
    .verdict_stall (verdict_stall),
    .verdict       (verdict)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap_max();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 3;
      default: return 18;
    endcase
  endfunction

  function automatic logic [7:0] rand_ext_type();
    return ext_kinds[$urandom_range(0, 4)];
  endfunction

  function automatic logic [7:0] rand_proto();
    case ($urandom_range(0, 3))
      0: return itc_pkg::PROTO_TCP;
      1: return itc_pkg::PROTO_UDP;
      2: return rand_ext_type();
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void cut_to(input int n);
    while (pkt_bytes.size() > n) void'(pkt_bytes.pop_back());
  endfunction

  function automatic void make_v4(input logic [7:0] proto, input int tail);
    pkt_bytes = {};
    repeat (20 + tail) pkt_bytes.push_back(8'($urandom));
    pkt_bytes[0] = {itc_pkg::VER_IPV4, pkt_bytes[0][3:0]};
    pkt_bytes[itc_pkg::IPV4_PROTO_IDX] = proto;
  endfunction

  function automatic void make_foreign(input int n);
    logic [3:0] nib;
    pkt_bytes = {};
    repeat (n) pkt_bytes.push_back(8'($urandom));
    do nib = 4'($urandom); while (nib == itc_pkg::VER_IPV4 || nib == itc_pkg::VER_IPV6);
    pkt_bytes[0] = {nib, pkt_bytes[0][3:0]};
  endfunction

  // ipv6 base header followed by one extension header per chain entry but the last
  function automatic void make_v6(input int len_lo, input int len_hi, input bit later,
                                  input int tail);
    int         start;
    int         span;
    logic [7:0] hlen;
    pkt_bytes = {};
    repeat (40) pkt_bytes.push_back(8'($urandom));
    pkt_bytes[0] = {itc_pkg::VER_IPV6, pkt_bytes[0][3:0]};
    pkt_bytes[itc_pkg::IPV6_NH_IDX] = chain[0];
    for (int k = 0; k + 1 < chain.size(); k++) begin
      start = pkt_bytes.size();
      hlen  = 8'($urandom_range(len_lo, len_hi));
      if (chain[k] == itc_pkg::PROTO_FRAG) span = 8;
      else if (chain[k] == itc_pkg::PROTO_AH) span = (int'(hlen) + 2) * 4;
      else span = (int'(hlen) + 1) * 8;
      repeat (span) pkt_bytes.push_back(8'($urandom));
      pkt_bytes[start] = chain[k + 1];
      if (chain[k] != itc_pkg::PROTO_FRAG) begin
        pkt_bytes[start + 1] = hlen;
      end else if (!later) begin
        pkt_bytes[start + 2] = 8'h00;
        pkt_bytes[start + 3] = {5'd0, pkt_bytes[start + 3][2:0]};
      end else if ($urandom_range(0, 1) == 0) begin
        pkt_bytes[start + 2] = 8'($urandom_range(1, 255));
      end else begin
        pkt_bytes[start + 3] = {5'($urandom_range(1, 31)), pkt_bytes[start + 3][2:0]};
      end
    end
    repeat (tail) pkt_bytes.push_back(8'($urandom));
  endfunction

  function automatic void rand_packet();
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      make_v4(rand_proto(), $urandom_range(0, 12));
    end else if (kind < 75) begin
      chain = {};
      repeat ($urandom_range(0, 4)) chain.push_back(rand_ext_type());
      chain.push_back(rand_proto());
      make_v6(0, ($urandom_range(0, 24) == 0) ? 31 : 1, $urandom_range(0, 4) == 0,
              $urandom_range(0, 6));
    end else if (kind < 85) begin
      make_foreign($urandom_range(1, 8));
    end else begin
      pkt_bytes = {};
      repeat ($urandom_range(1, 30)) pkt_bytes.push_back(8'($urandom));
    end
    if ($urandom_range(0, 4) == 0) cut_to($urandom_range(1, pkt_bytes.size()));
  endfunction

  // called at a rising edge; returns at the edge where the request is taken
  task automatic send_byte(input itc_pkg::pkt_t p, input int gap);
    if (gap > 0) begin
      pkt_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pkt_valid <= 1'b1;
    pkt       <= p;
    do @(posedge clk); while (pkt_stall);
    sb.note_request(p);
    bytes_sent++;
  endtask

  task automatic send_packet(input int gap_max);
    itc_pkg::pkt_t p;
    for (int k = 0; k < pkt_bytes.size(); k++) begin
      p.data_byte = pkt_bytes[k];
      p.last_byte = (k == pkt_bytes.size() - 1);
      send_byte(p, $urandom_range(0, gap_max));
    end
    packets_sent++;
  endtask

  task automatic drain_verdicts();
    int gap;
    forever begin
      if (sb.verdicts_seen % 8 == 0) recv_gap_max = pick_gap_max();
      // one long hold-off so the held verdict backs up into the byte channel
      if (sb.verdicts_seen == HOLD_AT) gap = HOLD_CYCLES;
      else gap = $urandom_range(0, recv_gap_max);
      if (gap > 0) begin
        verdict_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      verdict_stall <= 1'b0;
      do @(posedge clk); while (verdict_valid !== 1'b1);
      sb.check_verdict(verdict);
    end
  endtask

  initial begin : watchdog
    int quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (pkt_valid && !pkt_stall) || (verdict_valid && !verdict_stall)) quiet = 0;
      else quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : main
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    fork
      drain_verdicts();
    join_none

    // ipv4: match, trailing bytes, other protocol, truncated before and after protocol
    make_v4(itc_pkg::PROTO_TCP, 0);  send_packet(pick_gap_max());
    make_v4(itc_pkg::PROTO_UDP, 10); send_packet(pick_gap_max());
    make_v4(8'hFF, 3);               send_packet(pick_gap_max());
    make_v4(8'h00, 0);               send_packet(pick_gap_max());
    make_v4(itc_pkg::PROTO_TCP, 0);  cut_to(19); send_packet(pick_gap_max());
    make_v4(itc_pkg::PROTO_UDP, 0);  cut_to(9);  send_packet(pick_gap_max());
    make_v4(itc_pkg::PROTO_TCP, 0);  cut_to(1);  send_packet(pick_gap_max());
    // unknown versions
    make_foreign(1);  send_packet(pick_gap_max());
    make_foreign(12); pkt_bytes[0] = 8'hFF; send_packet(pick_gap_max());
    make_foreign(3);  pkt_bytes[0] = 8'h00; send_packet(pick_gap_max());
    // ipv6 base header only
    chain = {}; chain.push_back(itc_pkg::PROTO_TCP);
    make_v6(0, 0, 0, 0); send_packet(pick_gap_max());
    make_v6(0, 0, 0, 0); cut_to(39); send_packet(pick_gap_max());
    chain = {}; chain.push_back(itc_pkg::PROTO_UDP);
    make_v6(0, 0, 0, 5); send_packet(pick_gap_max());
    chain = {}; chain.push_back(8'd59);
    make_v6(0, 0, 0, 2); send_packet(pick_gap_max());
    // each extension type ahead of tcp
    foreach (ext_kinds[k]) begin
      chain = {}; chain.push_back(ext_kinds[k]); chain.push_back(itc_pkg::PROTO_TCP);
      make_v6(0, 2, 0, 1); send_packet(pick_gap_max());
    end
    chain = {};
    foreach (ext_kinds[k]) chain.push_back(ext_kinds[k]);
    chain.push_back(itc_pkg::PROTO_UDP);
    make_v6(0, 3, 0, 4); send_packet(pick_gap_max());
    // later fragment, complete and cut inside the fragment header
    chain = {}; chain.push_back(itc_pkg::PROTO_FRAG); chain.push_back(itc_pkg::PROTO_TCP);
    make_v6(0, 0, 1, 0); send_packet(pick_gap_max());
    make_v6(0, 0, 1, 0); cut_to(47); send_packet(pick_gap_max());
    // no byte left at the next header start; unknown type after routing
    chain = {}; chain.push_back(itc_pkg::PROTO_DSTOPT); chain.push_back(itc_pkg::PROTO_UDP);
    make_v6(0, 0, 0, 0); send_packet(pick_gap_max());
    chain = {}; chain.push_back(itc_pkg::PROTO_ROUTE); chain.push_back(8'hFF);
    make_v6(0, 1, 0, 1); send_packet(pick_gap_max());

    while (bytes_sent < ITEM_TARGET || packets_sent < PACKET_TARGET) begin
      rand_packet();
      send_packet(pick_gap_max());
    end
    pkt_valid <= 1'b0;

    while (sb.expected_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d packets (%0d bytes), checked %0d verdicts",
             packets_sent, bytes_sent, sb.verdicts_seen);
    $display("by status: match %0d, other %0d, truncated %0d, not ip %0d, later fragment %0d",
             sb.status_hist[0], sb.status_hist[1], sb.status_hist[2], sb.status_hist[3],
             sb.status_hist[4]);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
